// File: hdl/smpf_pkg.sv
// smpf_pkg: shared types, codes and point arithmetic for the smooth path flattener.
// Used by smpf_ctrl, smpf_datapath, smooth_path_flattener_top and the testbench. No dependencies.
package smpf_pkg;

   localparam logic [1:0] KIND_MOVE  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   localparam logic [1:0] CSR_SMOOTH = 2'd0;
   localparam logic [1:0] CSR_CLOSED = 2'd1;
   localparam logic [1:0] CSR_DEPTH  = 2'd2;

   // action bits of one transaction, served lowest first
   localparam int ACT_DRAW_START = 0;
   localparam int ACT_PIECE_A    = 1;
   localparam int ACT_PIECE_B    = 2;
   localparam int ACT_PIECE_C    = 3;
   localparam int ACT_DRAW_END   = 4;
   localparam int ACT_CLOSE      = 5;
   localparam int ACT_COUNT      = 6;

   localparam logic [13:0] NEAR_LIMIT = 14'd4096;

   typedef enum logic [1:0] {
      PIECE_LAST3 = 2'd0,  // (before previous, previous, point)
      PIECE_WRAP1 = 2'd1,  // (previous, point, first) or (p, p, p)
      PIECE_WRAP2 = 2'd2   // (point, first, second)
   } piece_sel_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
   } pt_type;

   typedef struct packed {
      logic          take;
      logic          emit_pt;
      logic          emit_close;
      logic          load;
      piece_sel_type sel;
      logic          step;
      logic          finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] seen;
      logic       fin;
      logic       smooth;
      logic       closed;
      logic       started;
      logic       busy;
      logic       can_emit;
      logic       out_free;
   } status_type;

   // (a+b)/2, truncating toward zero
   function automatic logic [31:0] half_c(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      logic [32:0] t;
      s = {a[31], a} + {b[31], b};
      t = s + {32'd0, s[32]};
      return t[32:1];
   endfunction

   // (s+2c+e)/4, truncating toward zero
   function automatic logic [31:0] mid_c(input logic [31:0] s, input logic [31:0] c,
                                         input logic [31:0] e);
      logic [34:0] sum;
      logic [34:0] t;
      sum = {{3{s[31]}}, s} + {{2{c[31]}}, c, 1'b0} + {{3{e[31]}}, e};
      t   = sum + (sum[34] ? 35'd3 : 35'd0);
      return t[33:2];
   endfunction

   function automatic pt_type half_pt(input pt_type a, input pt_type b);
      pt_type r;
      r.x = half_c(a.x, b.x);
      r.y = half_c(a.y, b.y);
      return r;
   endfunction

   function automatic pt_type mid_pt(input pt_type s, input pt_type c, input pt_type e);
      pt_type r;
      r.x = mid_c(s.x, c.x, e.x);
      r.y = mid_c(s.y, c.y, e.y);
      return r;
   endfunction

   // squared distance above 4096 square units; big offsets short-cut the square
   function automatic logic far_apart(input pt_type a, input pt_type b);
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [32:0]        ndx;
      logic [32:0]        ndy;
      logic [6:0]         ax;
      logic [6:0]         ay;
      logic [13:0]        sq;
      logic               big;
      dx  = $signed({a.x[31], a.x}) - $signed({b.x[31], b.x});
      dy  = $signed({a.y[31], a.y}) - $signed({b.y[31], b.y});
      ndx = 33'(-dx);
      ndy = 33'(-dy);
      big = (dx > 33'sd64) || (dx < -33'sd64) || (dy > 33'sd64) || (dy < -33'sd64);
      ax  = dx[32] ? ndx[6:0] : dx[6:0];
      ay  = dy[32] ? ndy[6:0] : dy[6:0];
      sq  = 14'(ax * ax) + 14'(ay * ay);
      return big || (sq > NEAR_LIMIT);
   endfunction

endpackage

// File: hdl/smpf_ctrl.sv
// smpf_ctrl: sequencer for one transaction: plans the action list, runs
// draws, pieces and close, then flushes. Depends on smpf_pkg.
module smpf_ctrl import smpf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PLAN  = 5'b00010,
      ST_DISP  = 5'b00100,
      ST_SUB   = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [ACT_COUNT-1:0]   todo_ff, todo_in;
   logic [ACT_COUNT-1:0]   plan;
   logic                   seen0;

   assign req_ready = (state_ff == ST_IDLE);
   assign seen0     = (status.seen == 2'd0);

   always_comb begin
      plan                 = '0;
      plan[ACT_DRAW_START] = !status.smooth || (seen0 && !status.closed);
      plan[ACT_PIECE_A]    = status.smooth && status.seen[1];
      plan[ACT_PIECE_B]    = status.smooth && status.fin && status.closed;
      plan[ACT_PIECE_C]    = status.smooth && status.fin && status.closed && !seen0;
      plan[ACT_DRAW_END]   = status.smooth && status.fin && !status.closed;
      plan[ACT_CLOSE]      = status.fin && status.closed && (status.smooth || !seen0);
   end

   always_comb begin
      state_in = state_ff;
      todo_in  = todo_ff;
      cmd      = '0;
      cmd.sel  = PIECE_LAST3;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            todo_in  = plan;
            state_in = ST_DISP;
         end
         ST_DISP: begin
            if (todo_ff == '0) begin
               state_in = ST_FLUSH;
            end else if (todo_ff[ACT_DRAW_START]) begin
               if (status.can_emit) begin
                  cmd.emit_pt             = 1'b1;
                  todo_in[ACT_DRAW_START] = 1'b0;
               end
            end else if (todo_ff[ACT_PIECE_A]) begin
               cmd.load             = 1'b1;
               cmd.sel              = PIECE_LAST3;
               todo_in[ACT_PIECE_A] = 1'b0;
               state_in             = ST_SUB;
            end else if (todo_ff[ACT_PIECE_B]) begin
               cmd.load             = 1'b1;
               cmd.sel              = PIECE_WRAP1;
               todo_in[ACT_PIECE_B] = 1'b0;
               state_in             = ST_SUB;
            end else if (todo_ff[ACT_PIECE_C]) begin
               cmd.load             = 1'b1;
               cmd.sel              = PIECE_WRAP2;
               todo_in[ACT_PIECE_C] = 1'b0;
               state_in             = ST_SUB;
            end else if (todo_ff[ACT_DRAW_END]) begin
               if (status.can_emit) begin
                  cmd.emit_pt           = 1'b1;
                  todo_in[ACT_DRAW_END] = 1'b0;
               end
            end else begin
               // close only once something was drawn
               if (!status.started) begin
                  todo_in[ACT_CLOSE] = 1'b0;
               end else if (status.can_emit) begin
                  cmd.emit_close     = 1'b1;
                  todo_in[ACT_CLOSE] = 1'b0;
               end
            end
         end
         ST_SUB: begin
            if (!status.busy) begin
               state_in = ST_DISP;
            end else if (status.can_emit) begin
               cmd.step = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         todo_ff  <= '0;
      end else begin
         state_ff <= state_in;
         todo_ff  <= todo_in;
      end
   end

endmodule

// File: hdl/smpf_datapath.sv
// smpf_datapath: path point storage, subdivision frame stack and the
// record hold/output registers. Depends on smpf_pkg.
module smpf_datapath import smpf_pkg::*; #(
   parameter int MAX_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic        req_final_point,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [1:0]  rsp_record_kind,
   output logic        rsp_run_end
);

   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   // path state
   pt_type     p_ff, prev_ff, pbp_ff, first_ff, second_ff;
   logic [1:0] seen_ff;
   logic       fin_ff, started_ff;
   logic       smooth_ff, closed_ff;
   logic [3:0] depth_ff;

   // subdivision: current frame in registers, saved parents on the stack
   pt_type          cur_s_ff, cur_c_ff, cur_e_ff;
   logic [LW-1:0]   cur_lvl_ff;
   logic            cur_ph_ff;
   logic            busy_ff;
   logic [SW-1:0]   sp_ff;
   pt_type          stk_s_ff [MAX_DEPTH];
   pt_type          stk_c_ff [MAX_DEPTH];
   pt_type          stk_e_ff [MAX_DEPTH];
   logic [LW-1:0]   stk_lvl_ff [MAX_DEPTH];

   // output side
   pt_type     hold_pt_ff, out_pt_ff;
   logic [1:0] hold_kind_ff, out_kind_ff;
   logic       hold_v_ff, out_v_ff, out_end_ff;

   pt_type        mid, sa, sb, sc;
   logic          far_l, far_r, deep, out_free, can_emit;
   logic          rec_en, draw_en;
   pt_type        rec_pt;
   logic [1:0]    rec_kind;
   logic [LW-1:0] root_lvl;
   logic [SW-1:0] sp_dn;

   assign mid   = mid_pt(cur_s_ff, cur_c_ff, cur_e_ff);
   assign far_l = far_apart(cur_c_ff, cur_s_ff);
   assign far_r = far_apart(cur_c_ff, cur_e_ff);
   assign deep  = (cur_lvl_ff > LW'(1));
   assign sp_dn = sp_ff - SW'(1);

   assign out_free = !out_v_ff || rsp_ready;
   assign can_emit = !hold_v_ff || out_free;

   assign root_lvl = (depth_ff > 4'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : LW'(depth_ff);

   always_comb begin
      case (cmd.sel)
         PIECE_LAST3: begin
            sa = pbp_ff; sb = prev_ff; sc = p_ff;
         end
         PIECE_WRAP1: begin
            if (seen_ff == 2'd0) begin
               sa = p_ff; sb = p_ff; sc = p_ff;
            end else begin
               sa = prev_ff; sb = p_ff; sc = first_ff;
            end
         end
         PIECE_WRAP2: begin
            sa = p_ff; sb = first_ff; sc = second_ff;
         end
         default: begin
            sa = p_ff; sb = p_ff; sc = p_ff;
         end
      endcase
   end

   always_comb begin
      draw_en  = cmd.emit_pt || (cmd.step && cur_ph_ff);
      rec_en   = draw_en || cmd.emit_close;
      rec_pt   = cmd.emit_close ? first_ff : (cmd.emit_pt ? p_ff : mid);
      rec_kind = cmd.emit_close ? KIND_CLOSE : (started_ff ? KIND_LINE : KIND_MOVE);
   end

   assign status.seen     = seen_ff;
   assign status.fin      = fin_ff;
   assign status.smooth   = smooth_ff;
   assign status.closed   = closed_ff;
   assign status.started  = started_ff;
   assign status.busy     = busy_ff;
   assign status.can_emit = can_emit;
   assign status.out_free = out_free;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= 1'b0;
         closed_ff <= 1'b1;
         depth_ff  <= 4'd4;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SMOOTH: smooth_ff <= csr_wdata[0];
            CSR_CLOSED: closed_ff <= csr_wdata[0];
            CSR_DEPTH:  depth_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // path state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= 2'd0;
         started_ff <= 1'b0;
         prev_ff    <= '0;
         pbp_ff     <= '0;
         first_ff   <= '0;
         second_ff  <= '0;
      end else begin
         if (cmd.take) begin
            if (seen_ff == 2'd0) begin
               first_ff   <= {req_point_x, req_point_y};
               started_ff <= 1'b0;
            end
            if (seen_ff == 2'd1) second_ff <= {req_point_x, req_point_y};
         end
         if (draw_en) started_ff <= 1'b1;
         if (cmd.finish) begin
            pbp_ff  <= prev_ff;
            prev_ff <= p_ff;
            if (fin_ff) begin
               seen_ff    <= 2'd0;
               started_ff <= 1'b0;
            end else if (seen_ff != 2'd3) begin
               seen_ff <= seen_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         p_ff   <= {req_point_x, req_point_y};
         fin_ff <= req_final_point;
      end
   end

   // subdivision walker
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.load) begin
         busy_ff <= (root_lvl != '0);
      end else if (cmd.step && cur_ph_ff && !(far_r && deep) && sp_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_s_ff   <= half_pt(sa, sb);
         cur_c_ff   <= sb;
         cur_e_ff   <= half_pt(sb, sc);
         cur_lvl_ff <= root_lvl;
         cur_ph_ff  <= 1'b0;
         sp_ff      <= '0;
      end else if (cmd.step) begin
         if (!cur_ph_ff) begin
            if (far_l && deep) begin
               stk_s_ff[sp_ff]   <= cur_s_ff;
               stk_c_ff[sp_ff]   <= cur_c_ff;
               stk_e_ff[sp_ff]   <= cur_e_ff;
               stk_lvl_ff[sp_ff] <= cur_lvl_ff;
               sp_ff             <= sp_ff + SW'(1);
               cur_c_ff          <= half_pt(cur_s_ff, cur_c_ff);
               cur_e_ff          <= mid;
               cur_lvl_ff        <= cur_lvl_ff - LW'(1);
            end else begin
               cur_ph_ff <= 1'b1;
            end
         end else if (far_r && deep) begin
            cur_s_ff   <= mid;
            cur_c_ff   <= half_pt(cur_c_ff, cur_e_ff);
            cur_lvl_ff <= cur_lvl_ff - LW'(1);
            cur_ph_ff  <= 1'b0;
         end else if (sp_ff != '0) begin
            // resume the parent with its left half done
            cur_s_ff   <= stk_s_ff[sp_dn];
            cur_c_ff   <= stk_c_ff[sp_dn];
            cur_e_ff   <= stk_e_ff[sp_dn];
            cur_lvl_ff <= stk_lvl_ff[sp_dn];
            cur_ph_ff  <= 1'b1;
            sp_ff      <= sp_dn;
         end
      end
   end

   // one record held back so the last one can carry run_end
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (rec_en) begin
            hold_v_ff <= 1'b1;
            if (hold_v_ff) out_v_ff <= 1'b1;
            else if (rsp_ready) out_v_ff <= 1'b0;
         end else if (cmd.finish) begin
            hold_v_ff <= 1'b0;
            if (hold_v_ff) out_v_ff <= 1'b1;
            else if (rsp_ready) out_v_ff <= 1'b0;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_en) begin
         hold_pt_ff   <= rec_pt;
         hold_kind_ff <= rec_kind;
      end
      if ((rec_en || cmd.finish) && hold_v_ff) begin
         out_pt_ff   <= hold_pt_ff;
         out_kind_ff <= hold_kind_ff;
         out_end_ff  <= cmd.finish;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_out_x       = out_pt_ff.x;
   assign rsp_out_y       = out_pt_ff.y;
   assign rsp_record_kind = out_kind_ff;
   assign rsp_run_end     = out_end_ff;

endmodule

// File: hdl/smooth_path_flattener_top.sv
// Smooth path flattener top: point stream in, move/line/close records out.
// A point is taken and planned, then its draws, pieces and close run and it is flushed;
// a smooth point also waits for the walker (load, then the frames of each piece).
// One transaction at a time: a new point is taken only once the current one is
// flushed. Output stalls stretch each transaction.
// Reset: synchronous active high; registers back to smooth 0, closed 1, depth 4.
module smooth_path_flattener_top import smpf_pkg::*; #(
   parameter int MAX_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // point transactions
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic        req_final_point,
   // record transactions
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [1:0]  rsp_record_kind,
   output logic        rsp_run_end,
   // register writes
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // controller: decides which draws, pieces and close a point causes
   smpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: point store, subdivision walker, output registers
   smpf_datapath #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_final_point  (req_final_point),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_run_end      (rsp_run_end)
   );

   // walker only steps on a live frame
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> status.busy) else $error("step without active frame");

   // flush needs a free output slot or the held record would be lost
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free) else $error("flush into full output");

   // one datapath command per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.emit_pt, cmd.emit_close, cmd.load, cmd.step, cmd.finish}))
      else $error("overlapping commands");

   // no new point until the current transaction is flushed
   a_seq: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("point taken while busy");

endmodule

// File: bench/tb_smooth_path_flattener_top.sv
// Testbench for smooth_path_flattener_top: directed and random point paths,
// checked record by record against an in-bench path flattening model.
// Depends on smpf_pkg (record kinds, register indexes) and the RTL top.
module tb_smooth_path_flattener_top;
   import smpf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOP_DEPTH   = 4;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic signed [63:0] x;
      logic signed [63:0] y;
   } coord_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [1:0]  kind;
      logic        last;
   } record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_point_x = '0;
   logic [31:0] req_point_y = '0;
   logic        req_final_point = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;
   logic [1:0]  rsp_record_kind;
   logic        rsp_run_end;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [3:0]  csr_wdata = '0;

   smooth_path_flattener_top #(.MAX_DEPTH(TOP_DEPTH)) dut (.*);

   always #10 clock = ~clock;

   // model state
   bit         mdl_smooth, mdl_closed;
   int         mdl_depth, piece_lvl;
   coord_type  prev_pt, prev2_pt, first_pt, second_pt;
   int         pts_seen;
   bit         started;
   record_type record_queue[$];
   record_type step_out[$];

   int  errors, checked, points_sent, idle_pct, stall_pct, stall_hold, quiet;
   bit  done;

   // ---------------- model ----------------
   function automatic coord_type halve(coord_type a, coord_type b);
      coord_type r;
      r.x = (a.x + b.x) / 2;
      r.y = (a.y + b.y) / 2;
      return r;
   endfunction

   function automatic bit spread(coord_type a, coord_type b);
      logic signed [63:0] dx, dy;
      dx = a.x - b.x;
      dy = a.y - b.y;
      if (dx > 64 || dx < -64 || dy > 64 || dy < -64) return 1;
      return dx * dx + dy * dy > 4096;
   endfunction

   function automatic void push_rec(coord_type p, logic [1:0] k);
      record_type r;
      r.x = p.x[31:0];
      r.y = p.y[31:0];
      r.kind = k;
      r.last = 1'b0;
      step_out.push_back(r);
   endfunction

   function automatic void plot(coord_type p);
      push_rec(p, started ? KIND_LINE : KIND_MOVE);
      started = 1;
   endfunction

   function automatic void split(coord_type s, coord_type c, coord_type e, int lvl);
      coord_type m;
      if (lvl == 0) return;
      m.x = (s.x + 2 * c.x + e.x) / 4;
      m.y = (s.y + 2 * c.y + e.y) / 4;
      if (spread(c, s)) split(s, halve(s, c), m, lvl - 1);
      plot(m);
      if (spread(c, e)) split(m, halve(c, e), e, lvl - 1);
   endfunction

   function automatic void curve(coord_type a, coord_type b, coord_type c);
      split(halve(a, b), b, halve(b, c), piece_lvl);
   endfunction

   function automatic void flatten_point(logic [31:0] px, logic [31:0] py, bit fin);
      coord_type p, pv;
      int seen;
      p.x = $signed(px);
      p.y = $signed(py);
      seen = pts_seen;
      step_out.delete();
      piece_lvl = mdl_depth > TOP_DEPTH ? TOP_DEPTH : mdl_depth;
      if (seen == 0) first_pt = p;
      if (seen == 1) second_pt = p;
      if (!mdl_smooth) begin
         if (seen == 0) started = 0;
         plot(p);
         if (fin && mdl_closed && seen > 0) push_rec(first_pt, KIND_CLOSE);
      end else begin
         if (seen == 0) begin
            started = 0;
            if (!mdl_closed) plot(p);
         end
         if (seen >= 2) curve(prev2_pt, prev_pt, p);
         if (fin) begin
            if (mdl_closed) begin
               if (seen == 0) curve(p, p, p);
               else begin
                  pv = prev_pt;
                  curve(pv, p, first_pt);
                  curve(p, first_pt, second_pt);
               end
               if (started) push_rec(first_pt, KIND_CLOSE);
            end else plot(p);
         end
      end
      prev2_pt = prev_pt;
      prev_pt = p;
      pts_seen = seen < 3 ? seen + 1 : 3;
      if (fin) begin
         pts_seen = 0;
         started = 0;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) record_queue.push_back(step_out[i]);
   endfunction

   // ---------------- drivers ----------------
   task automatic write_reg(logic [1:0] idx, logic [3:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_SMOOTH: mdl_smooth = val[0];
         CSR_CLOSED: mdl_closed = val[0];
         default:    mdl_depth = int'(val);
      endcase
   endtask

   // one point transaction; valid held until accepted
   task automatic send_point(logic [31:0] px, logic [31:0] py, bit fin);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_final_point <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      flatten_point(px, py, fin);
      points_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (record_queue.size() > 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic set_modes(bit sm, bit cl, int dp);
      drain();
      write_reg(CSR_SMOOTH, {3'b000, sm});
      write_reg(CSR_CLOSED, {3'b000, cl});
      write_reg(CSR_DEPTH, 4'(dp));
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(200)) - 100);
         default: return 32'($signed($urandom_range(4000)) - 2000);
      endcase
   endfunction

   // random path, mostly short well-formed paths
   task automatic send_path(int len);
      for (int i = 0; i < len; i++)
         send_point(rand_coord(), rand_coord(), i == len - 1);
   endtask

   // ---------------- tests ----------------
   task automatic test_straight();
      set_modes(0, 0, 4);
      send_path(1);
      send_path(3);
      set_modes(0, 1, 4);
      send_path(1);
      send_point(32'h7fff_ffff, 32'h8000_0000, 0);
      send_point(32'h8000_0000, 32'h7fff_ffff, 0);
      send_point(32'hffff_ffff, 32'h0, 1);
   endtask

   task automatic test_smooth_extremes();
      set_modes(1, 1, 8);
      send_point(0, 0, 1);                 // single point closed
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_point(32'h8000_0000, 32'h8000_0000, 0);
      send_point(32'h7fff_ffff, 32'h8000_0000, 1);
      set_modes(1, 0, 15);
      send_point(5, -5, 1);                // single point open
      send_point(0, 0, 0);
      send_point(64, 0, 0);                // near threshold
      send_point(-65, 65, 0);
      send_point(-3, 7, 1);
      set_modes(1, 1, 0);                  // depth zero: pieces silent
      send_path(3);
      set_modes(1, 1, 1);
      send_path(2);
   endtask

   task automatic test_mode_switch();
      // mode change mid path, ensures line-without-move handling
      set_modes(1, 1, 3);
      send_point(100, 100, 0);
      send_point(-100, 300, 0);
      set_modes(0, 1, 3);
      send_point(0, 0, 0);
      set_modes(1, 0, 2);
      send_point(400, -400, 1);
   endtask

   task automatic test_random(int n_points);
      int sent0;
      sent0 = points_sent;
      while (points_sent - sent0 < n_points) begin
         if ($urandom_range(15) == 0) begin
            set_modes(1'($urandom_range(1)), 1'($urandom_range(1)),
                      int'($urandom_range(8)));
         end
         send_path($urandom_range(3) == 0 ? $urandom_range(12, 1) : $urandom_range(5, 1));
      end
   endtask

   task automatic test_backpressure();
      set_modes(1, 1, 4);
      stall_hold = 400;                    // receiver holds off, sender keeps going
      send_path(6);
      drain();                             // sender pauses until all records arrive
      send_path(4);
   endtask

   // ---------------- receiver ----------------
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // check each record transaction against the oldest expected one
   always @(posedge clock) begin
      record_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         checked++;
         if (record_queue.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected record x=%h y=%h kind=%0d end=%b",
                        rsp_out_x, rsp_out_y, rsp_record_kind, rsp_run_end);
         end else begin
            want = record_queue.pop_front();
            if (want.x !== rsp_out_x || want.y !== rsp_out_y ||
                want.kind !== rsp_record_kind || want.last !== rsp_run_end) begin
               errors++;
               if (errors <= 10)
                  $display({"record mismatch: exp x=%h y=%h kind=%0d end=%b,",
                            " got x=%h y=%h kind=%0d end=%b"},
                           want.x, want.y, want.kind, want.last,
                           rsp_out_x, rsp_out_y, rsp_record_kind, rsp_run_end);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || done || reset)
         quiet <= 0;
      else begin
         quiet <= quiet + 1;
         if (quiet >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      mdl_smooth = 0;
      mdl_closed = 1;
      mdl_depth = 4;
      pts_seen = 0;
      started = 0;
      prev_pt = '{0, 0};
      prev2_pt = '{0, 0};
      first_pt = '{0, 0};
      second_pt = '{0, 0};
      idle_pct = 0;
      stall_pct = 0;
      stall_hold = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_straight();
      test_smooth_extremes();
      test_mode_switch();
      idle_pct = 0;  stall_pct = 0;  test_random(120);
      idle_pct = 69; stall_pct = 0;  test_random(120);
      idle_pct = 0;  stall_pct = 69; test_random(120);
      idle_pct = 37; stall_pct = 37; test_random(120);
      idle_pct = 0;  stall_pct = 0;  test_backpressure();

      drain();
      done = 1;
      $display("covered %0d points in straight/smooth, open/closed paths, depths 0..15",
               points_sent);
      $display("%0d records checked, %0d mismatches", checked, errors);
      if (errors == 0 && record_queue.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
